// ===== src/gclp_pkg.sv =====
// types and constants of the gc lifespan profiler
`timescale 1ns / 1ps
`default_nettype none

package gclp_pkg;

  localparam int unsigned ADDRESS_COUNT = 4096;
  localparam int unsigned ADDR_W        = 12;
  localparam int unsigned REC_W         = 32;
  localparam int unsigned LIFE_W        = 48;
  localparam int unsigned WSET_W        = 13;

  localparam logic [REC_W-1:0]  REC_MAX  = '1;
  localparam logic [LIFE_W-1:0] LIFE_MAX = '1;
  localparam logic [WSET_W-1:0] WSET_MAX = '1;

  typedef enum logic [1:0] {
    OP_WRITE    = 2'd0,
    OP_MIGRATE  = 2'd1,
    OP_READ_BIN = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0]  op;
    logic [11:0] lba;
    logic [31:0] wr_stamp;
    logic [3:0]  bin_select;
  } in_beat_t;

  typedef struct packed {
    logic              recorded;
    logic [3:0]        recorded_bin;
    logic [REC_W-1:0]  bin_records;
    logic [LIFE_W-1:0] bin_lifespan_total;
    logic [WSET_W-1:0] working_set;
  } out_beat_t;

endpackage

`default_nettype wire

// ===== src/gc_lifespan_profiler.sv =====
// top level of the gc lifespan profiler: address table, histogram and control
// Each event goes through these steps in order: the beat is accepted and the
// address table is read, then the table entry is updated and the histogram bin
// is read, then the bin is updated, once the output register is free, and the
// result is loaded into the output register. The next beat is accepted while a
// result still waits there. The rate is set by the two dependent memory reads,
// the histogram address coming from the table data. After reset the address table
// (flags and migration counts) is cleared one entry per cycle while input stays stalled.
`timescale 1ns / 1ps
`default_nettype none

module gc_lifespan_profiler
  import gclp_pkg::*;
#(
  parameter int unsigned BIN_COUNT = 16,
  parameter int unsigned TIME_BITS = 32
) (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            in_valid_i,
  output logic           in_stall_o,
  input  wire in_beat_t  in_data_i,
  output logic           out_valid_o,
  input  wire            out_stall_i,
  output out_beat_t      out_data_o
);

  localparam int unsigned BIN_W = $clog2(BIN_COUNT);
  localparam int unsigned SUM_W = ((TIME_BITS > LIFE_W) ? TIME_BITS : LIFE_W) + 1;
  localparam int unsigned HIST_W = REC_W + LIFE_W;
  localparam logic [BIN_W-1:0] CNT_MAX = BIN_W'(BIN_COUNT - 1);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(ADDRESS_COUNT - 1);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TABLE,
    ST_HIST
  } state_e;

  state_e state_q;
  logic [ADDR_W-1:0] clr_idx_q;
  in_beat_t item_q;
  logic [WSET_W-1:0] wset_q;
  logic out_valid_q;
  out_beat_t out_q;

  logic [BIN_W:0] tbl_mem [ADDRESS_COUNT];
  logic [TIME_BITS-1:0] time_mem [ADDRESS_COUNT];
  logic [HIST_W-1:0] hist_mem [BIN_COUNT];
  logic [BIN_COUNT-1:0] hist_vld_q;

  logic [BIN_W:0] tbl_rd_q;
  logic [TIME_BITS-1:0] time_rd_q;
  logic [HIST_W-1:0] hist_rd_q;
  logic hist_rd_vld_q;

  logic rec_q;
  logic [BIN_W-1:0] rec_bin_q;
  logic [TIME_BITS-1:0] life_q;
  logic sel_ok_q;

  logic accept;
  logic tbl_flag;
  logic [BIN_W-1:0] tbl_cnt;
  logic [TIME_BITS-1:0] now;
  logic do_rec;
  logic tbl_we;
  logic [ADDR_W-1:0] tbl_waddr;
  logic [BIN_W:0] tbl_wdata;
  logic time_we;
  logic [BIN_W-1:0] hist_raddr;
  logic [REC_W-1:0] cur_rec;
  logic [LIFE_W-1:0] cur_life;
  logic [SUM_W-1:0] life_sum;
  logic [REC_W-1:0] new_rec;
  logic [LIFE_W-1:0] new_life;
  logic hist_done;
  out_beat_t out_d;

  assign accept      = (state_q == ST_IDLE) && in_valid_i;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // table update
  assign tbl_flag = tbl_rd_q[BIN_W];
  assign tbl_cnt  = tbl_rd_q[BIN_W-1:0];
  assign now      = TIME_BITS'(item_q.wr_stamp);
  assign do_rec   = (item_q.op == OP_WRITE) && tbl_flag && (tbl_cnt != '0);

  always_comb begin
    tbl_we    = 1'b0;
    tbl_waddr = item_q.lba;
    tbl_wdata = tbl_rd_q;
    time_we   = 1'b0;
    if (state_q == ST_CLEAR) begin
      tbl_we    = 1'b1;
      tbl_waddr = clr_idx_q;
      tbl_wdata = '0;
    end else if (state_q == ST_TABLE) begin
      case (item_q.op)
        OP_WRITE: begin
          tbl_we    = 1'b1;
          tbl_wdata = {1'b1, (do_rec ? {BIN_W{1'b0}} : tbl_cnt)};
          time_we   = 1'b1;
        end
        OP_MIGRATE: begin
          tbl_we    = 1'b1;
          tbl_wdata = {tbl_flag, ((tbl_cnt == CNT_MAX) ? tbl_cnt : tbl_cnt + 1'b1)};
        end
        default: begin
          tbl_we = 1'b0;
        end
      endcase
    end
  end

  assign hist_raddr = (item_q.op == OP_WRITE) ? tbl_cnt : BIN_W'(item_q.bin_select);

  // histogram update
  assign cur_rec  = hist_rd_vld_q ? hist_rd_q[HIST_W-1:LIFE_W] : '0;
  assign cur_life = hist_rd_vld_q ? hist_rd_q[LIFE_W-1:0] : '0;
  assign life_sum = SUM_W'(cur_life) + SUM_W'(life_q);
  assign new_life = (life_sum > SUM_W'(LIFE_MAX)) ? LIFE_MAX : life_sum[LIFE_W-1:0];
  assign new_rec  = (cur_rec == REC_MAX) ? REC_MAX : cur_rec + 1'b1;
  assign hist_done = (state_q == ST_HIST) && (!out_valid_q || !out_stall_i);

  always_comb begin
    out_d                    = '0;
    out_d.recorded           = rec_q;
    out_d.recorded_bin       = rec_q ? 4'(rec_bin_q) : 4'd0;
    out_d.working_set        = wset_q;
    if ((item_q.op == OP_READ_BIN) && sel_ok_q) begin
      out_d.bin_records        = cur_rec;
      out_d.bin_lifespan_total = cur_life;
    end
  end

  // memories
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      tbl_mem[tbl_waddr] <= tbl_wdata;
    end
    if (time_we) begin
      time_mem[item_q.lba] <= now;
    end
    if (accept) begin
      tbl_rd_q  <= tbl_mem[in_data_i.lba];
      time_rd_q <= time_mem[in_data_i.lba];
    end
  end

  always_ff @(posedge clk_i) begin
    if (hist_done && rec_q) begin
      hist_mem[rec_bin_q] <= {new_rec, new_life};
    end
    if (state_q == ST_TABLE) begin
      hist_rd_q <= hist_mem[hist_raddr];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q <= in_data_i;
    end
    if (state_q == ST_TABLE) begin
      rec_q         <= do_rec;
      rec_bin_q     <= tbl_cnt;
      life_q        <= now - time_rd_q;
      sel_ok_q      <= (32'(item_q.bin_select) < BIN_COUNT);
      hist_rd_vld_q <= hist_vld_q[hist_raddr];
    end
  end

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_idx_q   <= '0;
      wset_q      <= '0;
      hist_vld_q  <= '0;
      out_valid_q <= 1'b0;
      out_q       <= '0;
    end else begin
      out_valid_q <= hist_done || (out_valid_q && out_stall_i);
      case (state_q)
        ST_CLEAR: begin
          clr_idx_q <= clr_idx_q + 1'b1;
          if (clr_idx_q == LAST_ADDR) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            state_q <= ST_TABLE;
          end
        end
        ST_TABLE: begin
          if ((item_q.op == OP_WRITE) && !tbl_flag && (wset_q != WSET_MAX)) begin
            wset_q <= wset_q + 1'b1;
          end
          state_q <= ST_HIST;
        end
        ST_HIST: begin
          if (hist_done) begin
            if (rec_q) begin
              hist_vld_q[rec_bin_q] <= 1'b1;
            end
            out_q   <= out_d;
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  a_accept_to_table: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == ST_TABLE))
    else $error("accepted beat did not start a table update");

  a_wset_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ##1 (wset_q >= $past(wset_q)))
    else $error("working set count decreased");

  a_record_bin_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_HIST && rec_q) |-> (rec_bin_q != '0))
    else $error("record aimed at bin zero");

  a_result_from_hist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> ($past(state_q) == ST_HIST))
    else $error("result loaded outside histogram update");

endmodule

`default_nettype wire
